>>> hw/rtl/aar_pkg.sv
// Shared types, widths, constants and the arctangent table for the arc angle range unit.
package aar_pkg;

  localparam int CORDIC_STAGES = 28;
  localparam int TAB_DEPTH     = 32;
  localparam int IDX_W         = $clog2(TAB_DEPTH);

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int NORM_W      = DIFF_W + 1;
  localparam int NORM_STAGES = $clog2(NORM_W);
  localparam int XW          = NORM_W + 3;
  localparam int ZW          = 33;
  localparam int ANG_W       = 31;
  localparam int RND_W       = 29;
  localparam int END_W       = 32;

  localparam int SIDE_LEN = NORM_STAGES + CORDIC_STAGES + 3;
  localparam int FOLD_TAP = NORM_STAGES + CORDIC_STAGES;

  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [ANG_W-1:0] PI_Q28      = 31'd843314857;
  localparam logic [RND_W-1:0] HALF_PI_Q28 = 29'd421657428;
  localparam logic [ANG_W-1:0] TWO_PI_Q28  = 31'd1686629713;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cdc_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero_x;
    logic zero_y;
  } lane_flags_t;

  typedef struct packed {
    logic        degen;
    lane_flags_t s;
    lane_flags_t e;
  } side_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'h3243F6A8;
      5'd1:  v = 31'h1DAC6705;
      5'd2:  v = 31'h0FADBAFC;
      5'd3:  v = 31'h07F56EA6;
      5'd4:  v = 31'h03FEAB76;
      5'd5:  v = 31'h01FFD55B;
      5'd6:  v = 31'h00FFFAAA;
      5'd7:  v = 31'h007FFF55;
      5'd8:  v = 31'h003FFFEA;
      5'd9:  v = 31'h001FFFFD;
      5'd10: v = 31'h000FFFFF;
      5'd11: v = 31'h0007FFFF;
      5'd12: v = 31'h0003FFFF;
      5'd13: v = 31'h0001FFFF;
      5'd14: v = 31'h0000FFFF;
      5'd15: v = 31'h00007FFF;
      5'd16: v = 31'h00003FFF;
      5'd17: v = 31'h00001FFF;
      5'd18: v = 31'h00000FFF;
      5'd19: v = 31'h000007FF;
      5'd20: v = 31'h000003FF;
      5'd21: v = 31'h000001FF;
      5'd22: v = 31'h000000FF;
      5'd23: v = 31'h0000007F;
      5'd24: v = 31'h0000003F;
      5'd25: v = 31'h0000001F;
      5'd26: v = 31'h0000000F;
      5'd27: v = 31'h00000008;
      5'd28: v = 31'h00000004;
      5'd29: v = 31'h00000002;
      5'd30: v = 31'h00000001;
      default: v = 31'h00000000;
    endcase
    return $signed({{(ZW-31){1'b0}}, v});
  endfunction

endpackage

>>> hw/rtl/aar_norm.sv
// Pipelined normalizer: shifts a magnitude pair left until the larger has its top bit set.
module aar_norm (
  input  logic                      clk,
  input  logic [aar_pkg::NORM_W-1:0] ax,
  input  logic [aar_pkg::NORM_W-1:0] ay,
  output logic [aar_pkg::NORM_W-1:0] nx,
  output logic [aar_pkg::NORM_W-1:0] ny
);

  logic [aar_pkg::NORM_W-1:0] px [aar_pkg::NORM_STAGES+1];
  logic [aar_pkg::NORM_W-1:0] py [aar_pkg::NORM_STAGES+1];

  assign px[0] = ax;
  assign py[0] = ay;

  for (genvar s = 0; s < aar_pkg::NORM_STAGES; s++) begin : g_stage
    localparam int SH = 1 << (aar_pkg::NORM_STAGES - 1 - s);
    logic [aar_pkg::NORM_W-1:0] ov;
    logic                       shift;
    assign ov    = px[s] | py[s];
    assign shift = (ov[aar_pkg::NORM_W-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      px[s+1] <= shift ? (px[s] << SH) : px[s];
      py[s+1] <= shift ? (py[s] << SH) : py[s];
    end
  end

  assign nx = px[aar_pkg::NORM_STAGES];
  assign ny = py[aar_pkg::NORM_STAGES];

endmodule

>>> hw/rtl/aar_cordic_cell.sv
// One vectoring CORDIC rotation, registered.
module aar_cordic_cell (
  input  logic                     clk,
  input  logic [aar_pkg::IDX_W-1:0] idx,
  input  aar_pkg::cdc_t            in_c,
  output aar_pkg::cdc_t            out_c
);

  logic signed [aar_pkg::XW-1:0] xs;
  logic signed [aar_pkg::XW-1:0] ys;
  logic signed [aar_pkg::ZW-1:0] t;

  assign xs = $signed(in_c.x) >>> idx;
  assign ys = $signed(in_c.y) >>> idx;
  assign t  = aar_pkg::atan_q30(idx);

  always_ff @(posedge clk) begin
    if ($signed(in_c.y) > 0) begin
      out_c.x <= in_c.x + ys;
      out_c.y <= in_c.y - xs;
      out_c.z <= in_c.z + t;
    end else begin
      out_c.x <= in_c.x - ys;
      out_c.y <= in_c.y + xs;
      out_c.z <= in_c.z - t;
    end
  end

endmodule

>>> hw/rtl/aar_fold.sv
// Clamps and rounds the CORDIC angle, then folds it into the full circle (two stages).
module aar_fold (
  input  logic                            clk,
  input  logic signed [aar_pkg::ZW-1:0]   z,
  input  aar_pkg::lane_flags_t            flags,
  output logic [aar_pkg::ANG_W-1:0]       angle
);

  logic [aar_pkg::ANG_W-1:0] zc;
  logic [aar_pkg::ANG_W:0]   sum;
  logic [aar_pkg::RND_W-1:0] a;
  aar_pkg::lane_flags_t      fl;

  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > $signed({2'b00, aar_pkg::HALF_PI_Q30})) begin
      zc = aar_pkg::HALF_PI_Q30;
    end else begin
      zc = z[aar_pkg::ANG_W-1:0];
    end
    sum = {1'b0, zc} + (aar_pkg::ANG_W+1)'(2);
  end

  always_ff @(posedge clk) begin
    fl <= flags;
    if (flags.zero_y) begin
      a <= '0;
    end else if (flags.zero_x) begin
      a <= aar_pkg::HALF_PI_Q28;
    end else begin
      a <= sum[aar_pkg::RND_W+1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (fl.neg_x) begin
      angle <= fl.neg_y ? aar_pkg::PI_Q28 + aar_pkg::ANG_W'(a)
                        : aar_pkg::PI_Q28 - aar_pkg::ANG_W'(a);
    end else if (fl.neg_y) begin
      angle <= (a == '0) ? '0 : aar_pkg::TWO_PI_Q28 - aar_pkg::ANG_W'(a);
    end else begin
      angle <= aar_pkg::ANG_W'(a);
    end
  end

endmodule

>>> hw/rtl/arc_angle_range_unit.sv
// Arc angle range unit: start and end angles of a planar arc via two pipelined CORDIC chains.
// Pipeline: input difference registers, normalizer stages, CORDIC cells, fold stages, output registers.
// Throughput: one arc per cycle; busy is low except during reset, no stall path.
// The chain of CORDIC cells sets the latency; every stage advances each cycle.
// Reset (rst, synchronous): clears the valid line and done; in-flight arcs are dropped.
module arc_angle_range_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [aar_pkg::COORD_W-1:0] center_x,
  input  logic signed [aar_pkg::COORD_W-1:0] center_y,
  input  logic signed [aar_pkg::COORD_W-1:0] start_x,
  input  logic signed [aar_pkg::COORD_W-1:0] start_y,
  input  logic signed [aar_pkg::COORD_W-1:0] end_x,
  input  logic signed [aar_pkg::COORD_W-1:0] end_y,
  output logic                            done,
  output logic [aar_pkg::ANG_W-1:0]       start_angle,
  output logic [aar_pkg::END_W-1:0]       end_angle,
  output logic                            degenerate
);

  localparam int DW = aar_pkg::DIFF_W;
  localparam int NW = aar_pkg::NORM_W;
  localparam int XW = aar_pkg::XW;
  localparam int NC = aar_pkg::CORDIC_STAGES;

  logic signed [DW-1:0] dsx, dsy, dex, dey;
  logic [DW-1:0]        asx, asy, aex, aey;
  logic [NW-1:0]        nsx, nsy, nex, ney;

  logic                 vld  [aar_pkg::SIDE_LEN];
  aar_pkg::side_t       side [aar_pkg::SIDE_LEN];
  aar_pkg::side_t       side_in;

  aar_pkg::cdc_t        s_chain [NC+1];
  aar_pkg::cdc_t        e_chain [NC+1];

  logic [aar_pkg::ANG_W-1:0] t2, t3;
  logic [aar_pkg::END_W-1:0] e_unw;
  aar_pkg::side_t            side_out;

  assign busy = rst;

  always_ff @(posedge clk) begin
    dsx <= {start_x[aar_pkg::COORD_W-1], start_x} - {center_x[aar_pkg::COORD_W-1], center_x};
    dsy <= {start_y[aar_pkg::COORD_W-1], start_y} - {center_y[aar_pkg::COORD_W-1], center_y};
    dex <= {end_x[aar_pkg::COORD_W-1], end_x} - {center_x[aar_pkg::COORD_W-1], center_x};
    dey <= {end_y[aar_pkg::COORD_W-1], end_y} - {center_y[aar_pkg::COORD_W-1], center_y};
  end

  always_comb begin
    side_in.degen    = (start_x == center_x) && (start_y == center_y);
    side_in.s.neg_x  = start_x < center_x;
    side_in.s.neg_y  = start_y < center_y;
    side_in.s.zero_x = start_x == center_x;
    side_in.s.zero_y = start_y == center_y;
    side_in.e.neg_x  = end_x < center_x;
    side_in.e.neg_y  = end_y < center_y;
    side_in.e.zero_x = end_x == center_x;
    side_in.e.zero_y = end_y == center_y;
  end

  assign asx = dsx[DW-1] ? DW'(-dsx) : DW'(dsx);
  assign asy = dsy[DW-1] ? DW'(-dsy) : DW'(dsy);
  assign aex = dex[DW-1] ? DW'(-dex) : DW'(dex);
  assign aey = dey[DW-1] ? DW'(-dey) : DW'(dey);

  aar_norm u_norm_s (
    .clk (clk),
    .ax  ({1'b0, asx}),
    .ay  ({1'b0, asy}),
    .nx  (nsx),
    .ny  (nsy)
  );

  aar_norm u_norm_e (
    .clk (clk),
    .ax  ({1'b0, aex}),
    .ay  ({1'b0, aey}),
    .nx  (nex),
    .ny  (ney)
  );

  assign s_chain[0] = '{x: $signed(XW'(nsx)), y: $signed(XW'(nsy)), z: '0};
  assign e_chain[0] = '{x: $signed(XW'(nex)), y: $signed(XW'(ney)), z: '0};

  for (genvar k = 0; k < NC; k++) begin : g_cell
    aar_cordic_cell u_cell_s (
      .clk   (clk),
      .idx   (aar_pkg::IDX_W'(k)),
      .in_c  (s_chain[k]),
      .out_c (s_chain[k+1])
    );
    aar_cordic_cell u_cell_e (
      .clk   (clk),
      .idx   (aar_pkg::IDX_W'(k)),
      .in_c  (e_chain[k]),
      .out_c (e_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    side[0] <= side_in;
    for (int j = 1; j < aar_pkg::SIDE_LEN; j++) begin
      side[j] <= side[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < aar_pkg::SIDE_LEN; j++) begin
        vld[j] <= 1'b0;
      end
    end else begin
      vld[0] <= start && !busy;
      for (int j = 1; j < aar_pkg::SIDE_LEN; j++) begin
        vld[j] <= vld[j-1];
      end
    end
  end

  aar_fold u_fold_s (
    .clk   (clk),
    .z     (s_chain[NC].z),
    .flags (side[aar_pkg::FOLD_TAP].s),
    .angle (t2)
  );

  aar_fold u_fold_e (
    .clk   (clk),
    .z     (e_chain[NC].z),
    .flags (side[aar_pkg::FOLD_TAP].e),
    .angle (t3)
  );

  // unwrap end angle to at least the start angle
  assign side_out = side[aar_pkg::SIDE_LEN-1];
  assign e_unw    = (t3 < t2) ? aar_pkg::END_W'(t3) + aar_pkg::END_W'(aar_pkg::TWO_PI_Q28)
                              : aar_pkg::END_W'(t3);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[aar_pkg::SIDE_LEN-1];
    end
    degenerate  <= side_out.degen;
    start_angle <= side_out.degen ? '0 : t2;
    end_angle   <= side_out.degen ? '0 : e_unw;
  end

endmodule

>>> tb/arc_angle_checker.sv
// Checker for the arc angle range unit: predicts start/end angles per arc beat and compares results.
`timescale 1ns / 100ps

module arc_angle_checker #(
  parameter int STAGES = aar_pkg::CORDIC_STAGES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [aar_pkg::COORD_W-1:0] center_x,
  input  logic signed [aar_pkg::COORD_W-1:0] center_y,
  input  logic signed [aar_pkg::COORD_W-1:0] start_x,
  input  logic signed [aar_pkg::COORD_W-1:0] start_y,
  input  logic signed [aar_pkg::COORD_W-1:0] end_x,
  input  logic signed [aar_pkg::COORD_W-1:0] end_y,
  input  logic                               done,
  input  logic [aar_pkg::ANG_W-1:0]          start_angle,
  input  logic [aar_pkg::END_W-1:0]          end_angle,
  input  logic                               degenerate,
  output int                                 mismatches,
  output int                                 angles_due
);

  localparam logic [31:0] PI_Q28      = 32'd843314857;
  localparam logic [31:0] HALF_PI_Q28 = 32'd421657428;
  localparam logic [31:0] TWO_PI_Q28  = 32'd1686629713;
  localparam longint      HALF_PI_Q30 = 64'd1686629713;

  // atan(2^-i), Q2.30, truncated; entry 0 in the top word
  localparam logic [32*32-1:0] ATAN_Q30 = {
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [aar_pkg::ANG_W-1:0] start_angle;
    logic [aar_pkg::END_W-1:0] end_angle;
    logic                      degenerate;
  } arc_angles_t;

  arc_angles_t pending_angles[$];

  // vectoring CORDIC on a first-quadrant vector, both components nonzero
  function automatic logic [31:0] quadrant_angle(input logic [63:0] ax_in,
                                                 input logic [63:0] ay_in);
    logic [63:0] ax;
    logic [63:0] ay;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    ax = ax_in;
    ay = ay_in;
    while (((ax | ay) >> 33) == 0) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = ax;
    y = ay;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_Q30[(31 - i)*32 +: 32]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_Q30[(31 - i)*32 +: 32]);
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_Q30) z = HALF_PI_Q30;
    return 32'((z + 2) >>> 2);
  endfunction

  function automatic logic [31:0] direction_angle(input longint dx, input longint dy);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [31:0] a;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0 && ay == 0) return 32'd0;
    if (ay == 0) a = 32'd0;
    else if (ax == 0) a = HALF_PI_Q28;
    else a = quadrant_angle(ax, ay);
    if (dx < 0) return (dy >= 0) ? PI_Q28 - a : PI_Q28 + a;
    if (dy < 0) return (a == 0) ? 32'd0 : TWO_PI_Q28 - a;
    return a;
  endfunction

  function automatic arc_angles_t arc_angles(input logic signed [31:0] cx,
                                             input logic signed [31:0] cy,
                                             input logic signed [31:0] sx,
                                             input logic signed [31:0] sy,
                                             input logic signed [31:0] ex,
                                             input logic signed [31:0] ey);
    arc_angles_t r;
    logic [31:0] t_s;
    logic [31:0] t_e;
    r = '0;
    if (sx == cx && sy == cy) begin
      r.degenerate = 1'b1;
      return r;
    end
    t_s = direction_angle(longint'(sx) - longint'(cx), longint'(sy) - longint'(cy));
    t_e = direction_angle(longint'(ex) - longint'(cx), longint'(ey) - longint'(cy));
    r.start_angle = t_s[aar_pkg::ANG_W-1:0];
    r.end_angle   = (t_e < t_s) ? t_e + TWO_PI_Q28 : t_e;
    return r;
  endfunction

  always @(posedge clk) begin
    arc_angles_t want;
    if (rst) begin
      mismatches <= 0;
      angles_due <= 0;
    end else begin
      if (done) begin
        if (pending_angles.size() == 0) begin
          $display("%0t result with no arc outstanding: start %0d end %0d degenerate %0d",
                   $time, start_angle, end_angle, degenerate);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_angles.pop_front();
          if (want.start_angle !== start_angle || want.end_angle !== end_angle ||
              want.degenerate !== degenerate) begin
            if (want.start_angle !== start_angle)
              $display("%0t start_angle expected %0d actual %0d",
                       $time, want.start_angle, start_angle);
            if (want.end_angle !== end_angle)
              $display("%0t end_angle expected %0d actual %0d",
                       $time, want.end_angle, end_angle);
            if (want.degenerate !== degenerate)
              $display("%0t degenerate expected %0d actual %0d",
                       $time, want.degenerate, degenerate);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy)
        pending_angles.push_back(arc_angles(center_x, center_y, start_x, start_y,
                                            end_x, end_y));
      angles_due <= pending_angles.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the arc angle range testbench: clock, reset, arc stimulus and the final verdict.
`timescale 1ns / 100ps

module testbench;

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam int DRAIN_CYCLES = 2 * (aar_pkg::CORDIC_STAGES + 9) + 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] center_x = '0;
  logic signed [31:0] center_y = '0;
  logic signed [31:0] start_x = '0;
  logic signed [31:0] start_y = '0;
  logic signed [31:0] end_x = '0;
  logic signed [31:0] end_y = '0;
  logic done;
  logic [aar_pkg::ANG_W-1:0] start_angle;
  logic [aar_pkg::END_W-1:0] end_angle;
  logic degenerate;
  int mismatches;
  int angles_due;

  always #5 clk = ~clk;

  arc_angle_range_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .center_x(center_x), .center_y(center_y),
    .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y),
    .done(done), .start_angle(start_angle), .end_angle(end_angle),
    .degenerate(degenerate)
  );

  arc_angle_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .center_x(center_x), .center_y(center_y),
    .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y),
    .done(done), .start_angle(start_angle), .end_angle(end_angle),
    .degenerate(degenerate),
    .mismatches(mismatches), .angles_due(angles_due)
  );

  // present one arc and hold it until the beat is taken
  task automatic send_arc(input logic signed [31:0] cx, input logic signed [31:0] cy,
                          input logic signed [31:0] sx, input logic signed [31:0] sy,
                          input logic signed [31:0] ex, input logic signed [31:0] ey);
    start    <= 1'b1;
    center_x <= cx;
    center_y <= cy;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < 31) begin
      start    <= 1'b0;
      center_x <= $urandom;
      start_y  <= $urandom;
      end_x    <= $urandom;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] offset_any();
    return $signed($urandom) >>> $urandom_range(31);
  endfunction

  function automatic logic signed [31:0] coord_extreme();
    case ($urandom_range(4))
      0: return CMIN;
      1: return CMAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  initial begin
    logic signed [31:0] cx, cy, sx, sy, ex, ey;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_arc(0, 0, 0, 0, 0, 0);
    send_arc(CMAX, CMIN, CMAX, CMIN, 0, 0);
    send_arc(0, 0, 65536, 0, 0, 0);
    send_arc(0, 0, -65536, 0, 0, 65536);
    send_arc(0, 0, 0, 65536, 0, -65536);
    send_arc(0, 0, 0, -65536, 65536, 0);
    send_arc(0, 0, 1000, 2000, -3000, 5000);
    send_arc(0, 0, -3000, 5000, -7, -9);
    send_arc(0, 0, -7, -9, 11, -13);
    send_arc(0, 0, 11, -13, 1000, 2000);
    send_arc(0, 0, CMAX, -1, CMAX, 1);
    send_arc(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
    send_arc(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN);
    send_arc(0, 0, CMIN, -1, CMIN, 1);
    send_arc(5, -3, 100, 200, 100, 200);
    send_arc(0, 0, 1, 1, -1, 1);
    send_arc(CMAX, 0, CMIN, 0, CMAX, 0);
    send_arc(0, CMIN, 0, CMAX, 0, CMIN);
    send_arc(1, 1, 2, 1, 1, 0);
    send_arc(-1, -1, -1, -2, -2, -1);
    idle_gap();

    for (int n = 0; n < 450; n++) begin
      cx = $urandom;
      cy = $urandom;
      sx = cx + offset_any();
      sy = cy + offset_any();
      ex = cx + offset_any();
      ey = cy + offset_any();
      case ($urandom_range(9))
        0, 1: begin
          sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
        end
        5: begin
          sx = cx; sy = cy;
          if ($urandom_range(3) == 0) begin ex = cx; ey = cy; end
        end
        6: begin
          if ($urandom_range(1)) ex = cx; else ey = cy;
        end
        7: begin
          if ($urandom_range(1)) begin ex = cx; ey = cy; end
          else begin ex = sx; ey = sy; end
        end
        8: begin
          cx = coord_extreme(); cy = coord_extreme(); sx = coord_extreme();
          sy = coord_extreme(); ex = coord_extreme(); ey = coord_extreme();
        end
        9: begin
          if ($urandom_range(1)) sx = cx; else sy = cy;
        end
        default: ;
      endcase
      send_arc(cx, cy, sx, sy, ex, ey);
      if (n < 150 || n >= 250) idle_gap();
    end
    start <= 1'b0;

    while (angles_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
